/* sv/assert_macros.svh */
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define PRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/prc_pkg.sv */
package prc_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int RSQRT_STEPS = 3;
    localparam int OUT_MAX     = 16384;

    localparam logic [33:0] THREE_Q30 = 34'd3221225472;

    typedef enum logic [2:0] {
        REG_BASIS_RIGHT   = 3'd0,
        REG_BASIS_UP      = 3'd1,
        REG_BASIS_BACK    = 3'd2,
        REG_HALF_EXTENT_X = 3'd3,
        REG_HALF_EXTENT_Y = 3'd4,
        REG_STEP_X        = 3'd5,
        REG_STEP_Y        = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [11:0]        ray_pixel_x;
        logic [11:0]        ray_pixel_y;
    } ray_t;

    typedef struct packed {
        logic [47:0] basis_right;
        logic [47:0] basis_up;
        logic [47:0] basis_back;
        logic [31:0] half_extent_x;
        logic [31:0] half_extent_y;
        logic [31:0] step_x;
        logic [31:0] step_y;
    } cam_cfg_t;

    // unnormalized direction as sign and magnitude
    typedef struct packed {
        pixel_t           pix;
        logic [2:0]       neg;
        logic [2:0][62:0] mag;
    } dir_t;

    // block-normalized direction and the scaled sum of squares
    typedef struct packed {
        pixel_t           pix;
        logic             zero;
        logic             e_hi;
        logic [2:0]       neg;
        logic [2:0][29:0] mag;
        logic [31:0]      w;
    } norm_t;

    typedef struct packed {
        norm_t       nm;
        logic [31:0] y;
    } rs_t;

    function automatic logic [15:0] seed_lookup(input logic [3:0] idx);
        logic [15:0] seed;
        unique case (idx) inside
            [4'd0:4'd4]: seed = 16'd61788;
            4'd5:        seed = 16'd55889;
            4'd6:        seed = 16'd51411;
            4'd7:        seed = 16'd47861;
            4'd8:        seed = 16'd44957;
            4'd9:        seed = 16'd42525;
            4'd10:       seed = 16'd40450;
            4'd11:       seed = 16'd38651;
            4'd12:       seed = 16'd37073;
            4'd13:       seed = 16'd35673;
            4'd14:       seed = 16'd34421;
            default:     seed = 16'd33292;
        endcase
        return seed;
    endfunction

endpackage

/* sv/prc_offset.sv */
module prc_offset (
    input  logic              clk,
    input  logic              rst_n,
    input  prc_pkg::cam_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  prc_pkg::pixel_t   pix,
    output logic              out_valid,
    input  logic              out_ready,
    output prc_pkg::dir_t     dir
);

    logic [4:0] adv;
    logic [4:0] valid_reg;
    logic [4:0] valid_next;

    prc_pkg::pixel_t pix_reg [5];

    logic [11:0] cx;
    logic [11:0] cy;
    logic [44:0] prod_x_next;
    logic [44:0] prod_y_next;
    logic [44:0] prod_x_reg;
    logic [44:0] prod_y_reg;

    logic signed [46:0] ox_next;
    logic signed [46:0] oy_next;
    logic signed [46:0] ox_reg;
    logic signed [46:0] oy_reg;

    logic signed [62:0] pr_next [3];
    logic signed [62:0] pu_next [3];
    logic signed [62:0] pr_reg [3];
    logic signed [62:0] pu_reg [3];

    logic signed [63:0] d_next [3];
    logic signed [63:0] d_reg [3];

    logic [2:0]  neg_next;
    logic [2:0]  neg_reg;
    logic [62:0] mag_next [3];
    logic [62:0] mag_reg [3];

    always_comb
    begin
        adv[4] = !valid_reg[4] || out_ready;
        for (int k = 3; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = {valid_reg[3:0], in_valid};
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < 5; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // column and row through the pixel centre, in half steps
    always_comb
    begin
        cx = (32'(pix.pixel_x) >= 32'(prc_pkg::MAX_DIM)) ?
             12'(prc_pkg::MAX_DIM - 1) : pix.pixel_x;
        cy = (32'(pix.pixel_y) >= 32'(prc_pkg::MAX_DIM)) ?
             12'(prc_pkg::MAX_DIM - 1) : pix.pixel_y;
        prod_x_next = 45'({cx, 1'b1}) * 45'(cfg.step_x);
        prod_y_next = 45'({cy, 1'b1}) * 45'(cfg.step_y);
    end

    always_comb
    begin
        ox_next = 47'(prod_x_reg) - 47'({cfg.half_extent_x, 1'b0});
        oy_next = 47'({cfg.half_extent_y, 1'b0}) - 47'(prod_y_reg);
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pr_next[c] = 63'(ox_reg) * 63'($signed(cfg.basis_right[16*c +: 16]));
            pu_next[c] = 63'(oy_reg) * 63'($signed(cfg.basis_up[16*c +: 16]));
            d_next[c]  = 64'(pr_reg[c]) + 64'(pu_reg[c])
                       - (64'($signed(cfg.basis_back[16*c +: 16])) <<< 25);
            neg_next[c] = d_reg[c][63];
            mag_next[c] = d_reg[c][63] ? 63'(-d_reg[c]) : 63'(d_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pix_reg[0] <= pix;
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (adv[1])
        begin
            pix_reg[1] <= pix_reg[0];
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
        end
        if (adv[2])
        begin
            pix_reg[2] <= pix_reg[1];
            pr_reg     <= pr_next;
            pu_reg     <= pu_next;
        end
        if (adv[3])
        begin
            pix_reg[3] <= pix_reg[2];
            d_reg      <= d_next;
        end
        if (adv[4])
        begin
            pix_reg[4] <= pix_reg[3];
            neg_reg    <= neg_next;
            mag_reg    <= mag_next;
        end
    end

    always_comb
    begin
        dir.pix = pix_reg[4];
        dir.neg = neg_reg;
        for (int c = 0; c < 3; c++)
        begin
            dir.mag[c] = mag_reg[c];
        end
    end

endmodule

/* sv/prc_norm.sv */
`include "assert_macros.svh"

module prc_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  prc_pkg::dir_t   dir,
    output logic            out_valid,
    input  logic            out_ready,
    output prc_pkg::rs_t    rs
);

    logic [5:0] adv;
    logic [5:0] valid_reg;
    logic [5:0] valid_next;

    prc_pkg::pixel_t pix_reg [6];
    logic [2:0]      neg_reg [6];

    // stage 1: chunk flags of the or of all magnitudes
    logic [63:0]      orv;
    logic [7:0]       nz_next;
    logic [7:0][2:0]  pos_next;
    logic [7:0]       nz_reg;
    logic [7:0][2:0]  pos_reg;
    logic [62:0]      m1_reg [3];

    // stage 2: top bit position
    logic [5:0]  p_next;
    logic [5:0]  p_reg;
    logic        zero2_reg;
    logic [62:0] m2_reg [3];

    // stage 3: shift to [2^29, 2^30)
    logic [29:0] m30_next [3];
    logic [29:0] m30_reg [3];
    logic        zero3_reg;

    // stage 4: squares
    logic [59:0] sq_next [3];
    logic [59:0] sq_reg [3];
    logic [29:0] m4_reg [3];
    logic        zero4_reg;

    // stage 5: sum and even exponent split
    logic [61:0] s_sum;
    logic        e_hi_next;
    logic [31:0] w_next;
    logic [31:0] w_reg;
    logic        e_hi_reg;
    logic [29:0] m5_reg [3];
    logic        zero5_reg;

    // stage 6: seed
    prc_pkg::norm_t nm_reg;
    logic [31:0]    y_reg;

    always_comb
    begin
        adv[5] = !valid_reg[5] || out_ready;
        for (int k = 4; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = {valid_reg[4:0], in_valid};
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_comb
    begin
        orv = {1'b0, dir.mag[0] | dir.mag[1] | dir.mag[2]};
        for (int j = 0; j < 8; j++)
        begin
            nz_next[j]  = |orv[8*j +: 8];
            pos_next[j] = 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                if (orv[8*j + i])
                begin
                    pos_next[j] = 3'(i);
                end
            end
        end
    end

    always_comb
    begin
        p_next = 6'd0;
        for (int j = 0; j < 8; j++)
        begin
            if (nz_reg[j])
            begin
                p_next = {3'(j), pos_reg[j]};
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (p_reg > 6'd29)
            begin
                m30_next[c] = 30'(m2_reg[c] >> (p_reg - 6'd29));
            end
            else
            begin
                m30_next[c] = 30'(m2_reg[c] << (6'd29 - p_reg));
            end
            sq_next[c] = 60'(m30_reg[c]) * 60'(m30_reg[c]);
        end
    end

    // the largest square is at least 2^58, so the exponent is 28 or 30
    always_comb
    begin
        s_sum     = 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
        e_hi_next = |s_sum[61:60];
        w_next    = e_hi_next ? s_sum[61:30] : s_sum[59:28];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pix_reg[0] <= dir.pix;
            neg_reg[0] <= dir.neg;
            nz_reg     <= nz_next;
            pos_reg    <= pos_next;
            for (int c = 0; c < 3; c++)
            begin
                m1_reg[c] <= dir.mag[c];
            end
        end
        if (adv[1])
        begin
            pix_reg[1] <= pix_reg[0];
            neg_reg[1] <= neg_reg[0];
            p_reg      <= p_next;
            zero2_reg  <= ~|nz_reg;
            m2_reg     <= m1_reg;
        end
        if (adv[2])
        begin
            pix_reg[2] <= pix_reg[1];
            neg_reg[2] <= neg_reg[1];
            m30_reg    <= m30_next;
            zero3_reg  <= zero2_reg;
        end
        if (adv[3])
        begin
            pix_reg[3] <= pix_reg[2];
            neg_reg[3] <= neg_reg[2];
            sq_reg     <= sq_next;
            m4_reg     <= m30_reg;
            zero4_reg  <= zero3_reg;
        end
        if (adv[4])
        begin
            pix_reg[4] <= pix_reg[3];
            neg_reg[4] <= neg_reg[3];
            w_reg      <= w_next;
            e_hi_reg   <= e_hi_next;
            m5_reg     <= m4_reg;
            zero5_reg  <= zero4_reg;
        end
        if (adv[5])
        begin
            pix_reg[5]  <= pix_reg[4];
            neg_reg[5]  <= neg_reg[4];
            nm_reg.pix  <= pix_reg[4];
            nm_reg.zero <= zero5_reg;
            nm_reg.e_hi <= e_hi_reg;
            nm_reg.neg  <= neg_reg[4];
            nm_reg.w    <= w_reg;
            for (int c = 0; c < 3; c++)
            begin
                nm_reg.mag[c] <= m5_reg[c];
            end
            y_reg <= {2'b00, prc_pkg::seed_lookup(w_reg[31:28]), 14'd0};
        end
    end

    always_comb
    begin
        rs.nm     = nm_reg;
        rs.nm.pix = pix_reg[5];
        rs.nm.neg = neg_reg[5];
        rs.y      = y_reg;
    end

    // after the shift the largest magnitude has bit 29 set
    `PRC_ASSERT_IMP(a_norm_top_bit, valid_reg[2] && !zero3_reg,
        m30_reg[0][29] || m30_reg[1][29] || m30_reg[2][29])

    // a nonzero direction leaves a sum of squares of at least 2^58
    `PRC_ASSERT_IMP(a_norm_w_range, valid_reg[4] && !zero5_reg, w_reg[31:30] != 2'b00)

    // a held output transaction stays put
    `PRC_ASSERT_NEXT(a_norm_hold, out_valid && !out_ready, out_valid && $stable(rs))

endmodule

/* sv/prc_rsqrt_step.sv */
module prc_rsqrt_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  prc_pkg::rs_t  rs_in,
    output logic          out_valid,
    input  logic          out_ready,
    output prc_pkg::rs_t  rs_out
);

    logic [2:0] adv;
    logic [2:0] valid_reg;
    logic [2:0] valid_next;

    prc_pkg::rs_t stg_reg [3];

    logic [63:0] yy;
    logic [31:0] t_next;
    logic [31:0] t_reg;
    logic [63:0] wt;
    logic [33:0] u;
    logic [31:0] f_next;
    logic [31:0] f_reg;
    logic [63:0] yf;
    logic [31:0] y_next;

    always_comb
    begin
        adv[2] = !valid_reg[2] || out_ready;
        for (int k = 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = {valid_reg[1:0], in_valid};
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // y <- y * (3 - w*y*y) / 2, all in Q30
    always_comb
    begin
        yy     = 64'(rs_in.y) * 64'(rs_in.y);
        t_next = yy[61:30];
        wt     = 64'(stg_reg[0].nm.w) * 64'(t_reg);
        u      = wt[63:30];
        f_next = (u > prc_pkg::THREE_Q30) ? 32'd0 : 32'(prc_pkg::THREE_Q30 - u);
        yf     = 64'(stg_reg[1].y) * 64'(f_reg);
        y_next = yf[62:31];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            stg_reg[0] <= rs_in;
            t_reg      <= t_next;
        end
        if (adv[1])
        begin
            stg_reg[1] <= stg_reg[0];
            f_reg      <= f_next;
        end
        if (adv[2])
        begin
            stg_reg[2].nm <= stg_reg[1].nm;
            stg_reg[2].y  <= y_next;
        end
    end

    assign rs_out = stg_reg[2];

endmodule

/* sv/prc_scale.sv */
module prc_scale (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  prc_pkg::rs_t  rs,
    output logic          out_valid,
    input  logic          out_ready,
    output prc_pkg::ray_t ray
);

    logic [1:0] adv;
    logic [1:0] valid_reg;
    logic [1:0] valid_next;

    logic [61:0]     prod_next [3];
    logic [61:0]     prod_reg [3];
    prc_pkg::pixel_t pix_reg;
    logic [2:0]      neg_reg;
    logic            zero_reg;
    logic            e_hi_reg;

    logic [61:0]        rnd [3];
    logic [61:0]        r_full [3];
    logic [14:0]        sat [3];
    logic signed [15:0] d_next [3];
    prc_pkg::ray_t      ray_reg;

    always_comb
    begin
        adv[1] = !valid_reg[1] || out_ready;
        adv[0] = !valid_reg[0] || adv[1];
        valid_next = {valid_reg[0], in_valid};
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < 2; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c] = 62'(rs.nm.mag[c]) * 62'(rs.y);
        end
    end

    // round half up at bit 46 or 45, then clip to one
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (e_hi_reg)
            begin
                rnd[c]    = prod_reg[c] + (62'd1 << 45);
                r_full[c] = rnd[c] >> 46;
            end
            else
            begin
                rnd[c]    = prod_reg[c] + (62'd1 << 44);
                r_full[c] = rnd[c] >> 45;
            end
            sat[c] = (r_full[c] > 62'(prc_pkg::OUT_MAX)) ?
                     15'(prc_pkg::OUT_MAX) : r_full[c][14:0];
            if (zero_reg)
            begin
                d_next[c] = 16'sd0;
            end
            else if (neg_reg[c])
            begin
                d_next[c] = -$signed(16'(sat[c]));
            end
            else
            begin
                d_next[c] = $signed(16'(sat[c]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg <= prod_next;
            pix_reg  <= rs.nm.pix;
            neg_reg  <= rs.nm.neg;
            zero_reg <= rs.nm.zero;
            e_hi_reg <= rs.nm.e_hi;
        end
        if (adv[1])
        begin
            ray_reg.dir_x       <= d_next[0];
            ray_reg.dir_y       <= d_next[1];
            ray_reg.dir_z       <= d_next[2];
            ray_reg.ray_pixel_x <= pix_reg.pixel_x;
            ray_reg.ray_pixel_y <= pix_reg.pixel_y;
        end
    end

    assign ray = ray_reg;

endmodule

/* sv/pinhole_camera_ray_direction.sv */
// throughput: one pixel per cycle while ray_ready does not hold the output;
// 5 offset, 6 normalize, 3 per newton step, 2 scale stages
// each stage holds its item while the next one is full, so bubbles close up
// reset: rst_n clears all stage valid bits and loads the register defaults
// (zero basis, half extents 1.0, zero steps); no clearing pass
`include "assert_macros.svh"

module pinhole_camera_ray_direction (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pixel_valid,
    output logic            pixel_ready,
    input  prc_pkg::pixel_t pixel,
    output logic            ray_valid,
    input  logic            ray_ready,
    output prc_pkg::ray_t   ray,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [47:0]     cfg_data
);

    prc_pkg::cam_cfg_t cfg_reg;

    logic          off_valid;
    logic          off_ready;
    prc_pkg::dir_t off_dir;

    logic         chain_valid [prc_pkg::RSQRT_STEPS + 1];
    logic         chain_ready [prc_pkg::RSQRT_STEPS + 1];
    prc_pkg::rs_t chain_data  [prc_pkg::RSQRT_STEPS + 1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.basis_right   <= '0;
            cfg_reg.basis_up      <= '0;
            cfg_reg.basis_back    <= '0;
            cfg_reg.half_extent_x <= 32'h0100_0000;
            cfg_reg.half_extent_y <= 32'h0100_0000;
            cfg_reg.step_x        <= '0;
            cfg_reg.step_y        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                prc_pkg::REG_BASIS_RIGHT:   cfg_reg.basis_right   <= cfg_data;
                prc_pkg::REG_BASIS_UP:      cfg_reg.basis_up      <= cfg_data;
                prc_pkg::REG_BASIS_BACK:    cfg_reg.basis_back    <= cfg_data;
                prc_pkg::REG_HALF_EXTENT_X: cfg_reg.half_extent_x <= cfg_data[31:0];
                prc_pkg::REG_HALF_EXTENT_Y: cfg_reg.half_extent_y <= cfg_data[31:0];
                prc_pkg::REG_STEP_X:        cfg_reg.step_x        <= cfg_data[31:0];
                prc_pkg::REG_STEP_Y:        cfg_reg.step_y        <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    prc_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (pixel_valid),
        .in_ready  (pixel_ready),
        .pix       (pixel),
        .out_valid (off_valid),
        .out_ready (off_ready),
        .dir       (off_dir)
    );

    prc_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (off_valid),
        .in_ready  (off_ready),
        .dir       (off_dir),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .rs        (chain_data[0])
    );

    for (genvar i = 0; i < prc_pkg::RSQRT_STEPS; i++)
    begin : g_newton
        prc_rsqrt_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .rs_in     (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .rs_out    (chain_data[i+1])
        );
    end

    prc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[prc_pkg::RSQRT_STEPS]),
        .in_ready  (chain_ready[prc_pkg::RSQRT_STEPS]),
        .rs        (chain_data[prc_pkg::RSQRT_STEPS]),
        .out_valid (ray_valid),
        .out_ready (ray_ready),
        .ray       (ray)
    );

    // components never leave the unit range
    `PRC_ASSERT_IMP(a_dir_range, ray_valid,
        ray.dir_x <= 16'sd16384 && ray.dir_x >= -16'sd16384 &&
        ray.dir_y <= 16'sd16384 && ray.dir_y >= -16'sd16384 &&
        ray.dir_z <= 16'sd16384 && ray.dir_z >= -16'sd16384)

    // input back-pressure only when every stage is full and the output is held
    `PRC_ASSERT_IMP(a_full_stall, !pixel_ready, ray_valid && !ray_ready)

    // a held output transaction stays put
    `PRC_ASSERT_NEXT(a_out_hold, ray_valid && !ray_ready, ray_valid && $stable(ray))

endmodule

/* tb/testbench.sv */
module testbench;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    logic              clk;
    logic              rst_n;
    logic              pixel_valid;
    logic              pixel_ready;
    prc_pkg::pixel_t   pixel;
    logic              ray_valid;
    logic              ray_ready;
    prc_pkg::ray_t     ray;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [47:0]       cfg_data;

    prc_pkg::cam_cfg_t cam;
    prc_pkg::ray_t     expected_rays[$];
    int                error_count;
    int                cycle_count;
    int                gap_max;
    int                stall_max;
    int                stall_left;
    bit                ray_hold;

    pinhole_camera_ray_direction uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .pixel      (pixel),
        .ray_valid  (ray_valid),
        .ray_ready  (ray_ready),
        .ray        (ray),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [63:0] basis_comp(input logic [47:0] v, input int i);
        logic signed [15:0] b;
        b = v[16*i +: 16];
        return b;
    endfunction

    function automatic int msb_pos(input logic [63:0] v);
        int p;
        p = -1;
        while (v != 0)
        begin
            v = v >> 1;
            p++;
        end
        return p;
    endfunction

    function automatic prc_pkg::ray_t predict_ray(input prc_pkg::pixel_t p);
        prc_pkg::ray_t      r;
        logic [63:0]        cx, cy, maxm, s, w, y, t, u, f, q;
        logic signed [63:0] ox, oy, d;
        logic [63:0]        mag[3];
        bit                 neg[3];
        logic [15:0]        seeds[16];
        int                 pb, top, e, sh;
        seeds = '{16'd61788, 16'd61788, 16'd61788, 16'd61788, 16'd61788, 16'd55889,
                  16'd51411, 16'd47861, 16'd44957, 16'd42525, 16'd40450, 16'd38651,
                  16'd37073, 16'd35673, 16'd34421, 16'd33292};
        cx = (p.pixel_x >= prc_pkg::MAX_DIM) ? 64'(prc_pkg::MAX_DIM - 1) : 64'(p.pixel_x);
        cy = (p.pixel_y >= prc_pkg::MAX_DIM) ? 64'(prc_pkg::MAX_DIM - 1) : 64'(p.pixel_y);
        ox = $signed((2 * cx + 1) * 64'(cam.step_x)) - $signed(2 * 64'(cam.half_extent_x));
        oy = $signed(2 * 64'(cam.half_extent_y)) - $signed((2 * cy + 1) * 64'(cam.step_y));
        maxm = 0;
        for (int c = 0; c < 3; c++)
        begin
            d = ox * basis_comp(cam.basis_right, c) + oy * basis_comp(cam.basis_up, c)
                - basis_comp(cam.basis_back, c) * (64'sd1 <<< 25);
            neg[c] = d < 0;
            mag[c] = neg[c] ? 64'd0 - 64'(d) : 64'(d);
            if (mag[c] > maxm)
                maxm = mag[c];
        end
        r.ray_pixel_x = p.pixel_x;
        r.ray_pixel_y = p.pixel_y;
        if (maxm == 0)
        begin
            r.dir_x = '0;
            r.dir_y = '0;
            r.dir_z = '0;
            return r;
        end
        pb = msb_pos(maxm);
        s = 0;
        for (int c = 0; c < 3; c++)
        begin
            if (pb > 29)
                mag[c] = mag[c] >> (pb - 29);
            else if (pb < 29)
                mag[c] = mag[c] << (29 - pb);
            s = s + mag[c] * mag[c];
        end
        top = msb_pos(s);
        e = (top - 30) & ~1;
        if (e < 0)
            e = 0;
        w = s >> e;
        y = 64'(seeds[(w >> 28) & 15]) << 14;
        for (int i = 0; i < prc_pkg::RSQRT_STEPS; i++)
        begin
            t = (y * y) >> 30;
            u = (w * t) >> 30;
            f = (u > 64'(prc_pkg::THREE_Q30)) ? 64'd0 : 64'(prc_pkg::THREE_Q30) - u;
            y = (y * f) >> 31;
        end
        sh = 16 + (e + 30) / 2;
        for (int c = 0; c < 3; c++)
        begin
            q = (mag[c] * y + (64'd1 << (sh - 1))) >> sh;
            if (q > prc_pkg::OUT_MAX)
                q = prc_pkg::OUT_MAX;
            q = neg[c] ? 64'd0 - q : q;
            if (c == 0) r.dir_x = q[15:0];
            else if (c == 1) r.dir_y = q[15:0];
            else r.dir_z = q[15:0];
        end
        return r;
    endfunction

    // output side: check each ray transaction and draw the next stall
    always @(posedge clk)
    begin
        prc_pkg::ray_t exp_ray;
        if (rst_n && ray_valid && ray_ready)
        begin
            stall_left = (stall_max > 0) ? $urandom_range(stall_max, 0) : 0;
            if (expected_rays.size() == 0)
            begin
                $error("unexpected ray transaction for pixel %0d,%0d",
                       ray.ray_pixel_x, ray.ray_pixel_y);
                error_count++;
            end
            else
            begin
                exp_ray = expected_rays.pop_front();
                if (ray.dir_x !== exp_ray.dir_x)
                begin
                    $error("dir_x expected %0d actual %0d", exp_ray.dir_x, ray.dir_x);
                    error_count++;
                end
                if (ray.dir_y !== exp_ray.dir_y)
                begin
                    $error("dir_y expected %0d actual %0d", exp_ray.dir_y, ray.dir_y);
                    error_count++;
                end
                if (ray.dir_z !== exp_ray.dir_z)
                begin
                    $error("dir_z expected %0d actual %0d", exp_ray.dir_z, ray.dir_z);
                    error_count++;
                end
                if (ray.ray_pixel_x !== exp_ray.ray_pixel_x)
                begin
                    $error("ray_pixel_x expected %0d actual %0d",
                           exp_ray.ray_pixel_x, ray.ray_pixel_x);
                    error_count++;
                end
                if (ray.ray_pixel_y !== exp_ray.ray_pixel_y)
                begin
                    $error("ray_pixel_y expected %0d actual %0d",
                           exp_ray.ray_pixel_y, ray.ray_pixel_y);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (ray_hold)
            ray_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            ray_ready <= 1'b0;
            stall_left--;
        end
        else
            ray_ready <= 1'b1;
    end

    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
        int gap;
        gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel.pixel_x <= px;
        pixel.pixel_y <= py;
        do
            @(posedge clk);
        while (!pixel_ready);
        expected_rays.push_back(predict_ray('{pixel_x: px, pixel_y: py}));
    endtask

    task automatic drain_rays();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (expected_rays.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // only called with the pipeline drained
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            prc_pkg::REG_BASIS_RIGHT:   cam.basis_right   = data;
            prc_pkg::REG_BASIS_UP:      cam.basis_up      = data;
            prc_pkg::REG_BASIS_BACK:    cam.basis_back    = data;
            prc_pkg::REG_HALF_EXTENT_X: cam.half_extent_x = data[31:0];
            prc_pkg::REG_HALF_EXTENT_Y: cam.half_extent_y = data[31:0];
            prc_pkg::REG_STEP_X:        cam.step_x        = data[31:0];
            prc_pkg::REG_STEP_Y:        cam.step_y        = data[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_camera(input logic [47:0] rt, input logic [47:0] up,
                               input logic [47:0] bk, input logic [31:0] hx,
                               input logic [31:0] hy, input logic [31:0] sx,
                               input logic [31:0] sy);
        write_reg(prc_pkg::REG_BASIS_RIGHT, rt);
        write_reg(prc_pkg::REG_BASIS_UP, up);
        write_reg(prc_pkg::REG_BASIS_BACK, bk);
        write_reg(prc_pkg::REG_HALF_EXTENT_X, {16'd0, hx});
        write_reg(prc_pkg::REG_HALF_EXTENT_Y, {16'd0, hy});
        write_reg(prc_pkg::REG_STEP_X, {16'd0, sx});
        write_reg(prc_pkg::REG_STEP_Y, {16'd0, sy});
    endtask

    // zero basis after reset gives a zero direction
    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hAAA, 12'h555);
        drain_rays();
    endtask

    task automatic test_axis_camera();
        // right +x, up +y, back +z, 640x480 style steps
        load_camera({16'd0, 16'd0, 16'd16384}, {16'd0, 16'd16384, 16'd0},
                    {16'd16384, 16'd0, 16'd0}, 32'd22369621, 32'd16777216,
                    32'd69905, 32'd69905);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd319, 12'd239);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'hFFF);
        drain_rays();
        // index past the list must leave the camera alone
        write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_pixel(12'd100, 12'd200);
        drain_rays();
    endtask

    task automatic test_config_extremes();
        load_camera('1, '1, '1, '1, '1, '1, '1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        drain_rays();
        load_camera({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, '1, 32'd0, '1, 32'd0);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd2048, 12'd2048);
        drain_rays();
        // only the backward vector, so the offsets drop out
        load_camera('0, '0, {16'h7FFF, 16'h8001, 16'd1}, '0, '0, '0, '0);
        send_pixel(12'd5, 12'd7);
        send_pixel(12'hFFF, 12'hFFF);
        drain_rays();
    endtask

    task automatic test_random_cameras();
        logic [47:0] rt, up, bk;
        for (int phase = 0; phase < 10; phase++)
        begin
            rt = 48'({$urandom, $urandom});
            up = 48'({$urandom, $urandom});
            bk = 48'({$urandom, $urandom});
            if (phase % 3 == 0)
            begin
                rt = {16'($signed(14'($urandom))), 16'($signed(14'($urandom))),
                      16'($signed(14'($urandom)))};
                bk = {16'($urandom_range(16384, 0)), 16'd0, 16'($urandom_range(200, 0))};
            end
            load_camera(rt, up, bk, $urandom, $urandom, $urandom, $urandom);
            if (phase % 2 == 0)
            begin
                write_reg(prc_pkg::REG_STEP_X, {16'd0, 32'($urandom_range(400000, 0))});
                write_reg(prc_pkg::REG_STEP_Y, {16'd0, 32'($urandom_range(400000, 0))});
                write_reg(prc_pkg::REG_HALF_EXTENT_X,
                          {16'd0, 32'($urandom_range(50000000, 0))});
            end
            gap_max   = (phase % 4 == 1) ? 0 : 14;
            stall_max = (phase % 4 == 2) ? 0 : 14;
            for (int i = 0; i < 50; i++)
                send_pixel(12'($urandom), 12'($urandom));
            drain_rays();
        end
        gap_max   = 14;
        stall_max = 14;
    endtask

    task automatic test_output_holdoff();
        load_camera({16'd0, 16'd0, 16'd16384}, {16'd0, 16'd16384, 16'd0},
                    {16'd16384, 16'd0, 16'd0}, 32'd16777216, 32'd16777216,
                    32'd65536, 32'd65536);
        gap_max = 0;
        fork
            begin
                ray_hold = 1'b1;
                repeat (300) @(posedge clk);
                ray_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++)
                    send_pixel(12'($urandom_range(511, 0)), 12'($urandom_range(511, 0)));
            end
        join
        drain_rays();
        gap_max = 14;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        ray_ready   = 1'b0;
        ray_hold    = 1'b0;
        stall_left  = 0;
        error_count = 0;
        cycle_count = 0;
        gap_max     = 14;
        stall_max   = 14;
        cam         = '{basis_right: '0, basis_up: '0, basis_back: '0,
                        half_extent_x: 32'd16777216, half_extent_y: 32'd16777216,
                        step_x: '0, step_y: '0};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_axis_camera();
        test_config_extremes();
        test_random_cameras();
        test_output_holdoff();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
